>>> src/psgbox_pkg.sv
// Shared types, constants and the attenuation level table for the PSG sample unit.
package psgbox_pkg;

  localparam int unsigned TICK_CLOCKS  = 240;
  localparam int unsigned SAMPLE_CLOCKS = 1008;
  localparam int unsigned QUOT_W       = 14;
  localparam int unsigned MAG_W        = 20;
  localparam int unsigned ACC_W        = 25;
  localparam int unsigned VSUM_W       = 15;
  localparam int unsigned AMP_W        = 12;
  localparam int unsigned PER_W        = 10;
  localparam logic [15:0] NOISE_SEED   = 16'h8000;
  localparam logic [PER_W-1:0] NOISE_BASE = PER_W'(16);
  localparam logic [20:0] RECIP_63     = 21'd1065221;
  localparam int unsigned RECIP_SHIFT  = 26;
  localparam logic [1:0] RATE_TONE2    = 2'd3;
  localparam logic [1:0] CH_NOISE      = 2'd3;

  typedef struct packed {
    logic wr;
    logic start;
    logic seg;
    logic seg_first;
    logic seg_last;
    logic div_init;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] ticks;
  } stat_t;

  function automatic logic [AMP_W-1:0] level_of(input logic [3:0] att);
    logic [AMP_W-1:0] v;
    begin
      unique case (att)
        4'd0:  v = 12'd2800;
        4'd1:  v = 12'd2224;
        4'd2:  v = 12'd1767;
        4'd3:  v = 12'd1403;
        4'd4:  v = 12'd1115;
        4'd5:  v = 12'd886;
        4'd6:  v = 12'd704;
        4'd7:  v = 12'd559;
        4'd8:  v = 12'd444;
        4'd9:  v = 12'd353;
        4'd10: v = 12'd280;
        4'd11: v = 12'd222;
        4'd12: v = 12'd177;
        4'd13: v = 12'd140;
        4'd14: v = 12'd111;
        default: v = 12'd0;
      endcase
      return v;
    end
  endfunction

endpackage

>>> src/psgbox_if.sv
// Handshake channel interfaces for the request and sample beats.
interface psgbox_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data;
  modport source (output valid, output func, output data, input ready);
  modport sink   (input valid, input func, input data, output ready);
endinterface

interface psgbox_out_if;
  logic              valid;
  logic              ready;
  logic signed [14:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> src/square_psg_box_filtered_sample_unit.sv
// Top level of the four-voice square and noise sample unit.
//  channel | dir | beat payload       | note
//  in_ch   | in  | func, data         | func 0 writes a register byte, 1 asks a sample
//  out_ch  | out | sample (15b signed)| one beat per sample request
// A register write beat is taken in the idle state. A sample request walks an accept step and
// its tick segments, their number set by ticks (4 or 5), then a setup step, a reciprocal-multiply
// divide step and an emit step.
// Reset is synchronous and active low and restores the power-on voice state.
// A result waits in the output register; a following write beat is still taken.
// A finished sample that cannot enter the output register holds the unit in its emit cycle.
module square_psg_box_filtered_sample_unit (
  input  logic          clk,
  input  logic          rst_n,
  psgbox_in_if.sink     in_ch,
  psgbox_out_if.source  out_ch
);
  import psgbox_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  psgbox_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  psgbox_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_ch.data),
    .stat    (stat),
    .sample  (out_ch.sample)
  );

`ifndef SYNTH
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.wr, cmd.start, cmd.seg, cmd.div_init, cmd.div_step, cmd.emit}))
    else $error("controller issued overlapping commands");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready && in_ch.func |=> !in_ch.ready)
    else $error("sample request did not make the unit busy");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.sample >= -15'sd11200) && (out_ch.sample <= 15'sd11200))
    else $error("sample out of range");
`endif

endmodule

>>> src/psgbox_ctrl.sv
// Controller state machine sequencing register writes, tick segments and the divider.
module psgbox_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_func,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  psgbox_pkg::stat_t stat,
  output psgbox_pkg::cmd_t  cmd
);
  import psgbox_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SEG   = 5'b00010,
    ST_DINIT = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  state_t     state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_func) begin
            cmd.start = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SEG;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SEG: begin
        cmd.seg       = 1'b1;
        cmd.seg_first = (cnt_r == 4'd0);
        cmd.seg_last  = (cnt_r == {1'b0, stat.ticks});
        if (cmd.seg_last) begin
          state_nxt = ST_DINIT;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/psgbox_dp.sv
// Datapath holding voice state, the segment accumulator and the quotient divider.
module psgbox_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  psgbox_pkg::cmd_t   cmd,
  input  logic [7:0]         in_data,
  output psgbox_pkg::stat_t  stat,
  output logic signed [14:0] sample
);
  import psgbox_pkg::*;

  logic [PER_W-1:0] tp_r [3];
  logic [PER_W-1:0] cd_r [4];
  logic [PER_W-1:0] cd_nxt [4];
  logic [3:0]       att_r [4];
  logic [2:0]       mode_r;
  logic [2:0]       latch_r;
  logic [15:0]      lfsr_r, lfsr_nxt;
  logic [3:0]       high_r, high_nxt;
  logic             nph_r, nph_nxt;
  logic [7:0]       phase_r;
  logic [2:0]       ticks_r;
  logic [7:0]       first_len_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [MAG_W-1:0] m_r;
  logic [QUOT_W-1:0] q_r;
  logic             neg_r;
  logic signed [14:0] sample_r;

  logic [2:0]       latch_w;
  logic [1:0]       ch_w;
  logic [7:0]       len;
  logic signed [VSUM_W-1:0] vsum;
  logic signed [VSUM_W+8:0] prod;
  logic [ACC_W-1:0] mag;
  logic [MAG_W+20:0] qprod;
  logic             tone2_mode, shift_en;
  logic [PER_W-1:0] per;
  logic             fb;

  assign latch_w    = in_data[7] ? in_data[6:4] : latch_r;
  assign ch_w       = latch_w[2:1];
  assign tone2_mode = (mode_r[1:0] == RATE_TONE2);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      per = (tp_r[i] == '0) ? PER_W'(1) : tp_r[i];
      if (cd_r[i] <= PER_W'(1)) begin
        cd_nxt[i]   = per;
        high_nxt[i] = !high_r[i];
      end else begin
        cd_nxt[i]   = cd_r[i] - PER_W'(1);
        high_nxt[i] = high_r[i];
      end
    end
    cd_nxt[3] = cd_r[3];
    nph_nxt   = nph_r;
    if (tone2_mode) begin
      shift_en = (cd_r[2] <= PER_W'(1)) && !high_r[2];
    end else if (cd_r[3] <= PER_W'(1)) begin
      cd_nxt[3] = NOISE_BASE << mode_r[1:0];
      nph_nxt   = !nph_r;
      shift_en  = !nph_r;
    end else begin
      cd_nxt[3] = cd_r[3] - PER_W'(1);
      shift_en  = 1'b0;
    end
    fb = mode_r[2] ? (lfsr_r[0] ^ lfsr_r[3]) : lfsr_r[0];
    if (shift_en) begin
      lfsr_nxt    = {fb, lfsr_r[15:1]};
      high_nxt[3] = lfsr_r[1];
    end else begin
      lfsr_nxt    = lfsr_r;
      high_nxt[3] = high_r[3];
    end
  end

  always_comb begin
    vsum = '0;
    for (int i = 0; i < 4; i++) begin
      if (high_r[i]) begin
        vsum = vsum + $signed({3'b000, level_of(att_r[i])});
      end else begin
        vsum = vsum - $signed({3'b000, level_of(att_r[i])});
      end
    end
    if (cmd.seg_first) begin
      len = first_len_r;
    end else if (cmd.seg_last) begin
      len = phase_r;
    end else begin
      len = 8'(TICK_CLOCKS);
    end
    prod  = vsum * $signed({1'b0, len});
    mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
    qprod = m_r * RECIP_63;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) tp_r[i] <= PER_W'(1);
      for (int i = 0; i < 4; i++) begin
        cd_r[i]  <= PER_W'(1);
        att_r[i] <= 4'hf;
      end
      cd_r[3] <= NOISE_BASE;
      mode_r  <= '0;
      latch_r <= '0;
      lfsr_r  <= NOISE_SEED;
      high_r  <= '0;
      nph_r   <= 1'b0;
      phase_r <= '0;
      ticks_r <= 3'd4;
    end else begin
      if (cmd.wr) begin
        latch_r <= latch_w;
        if (latch_w[0]) begin
          att_r[ch_w] <= in_data[3:0];
        end else if (ch_w == CH_NOISE) begin
          mode_r <= in_data[2:0];
          lfsr_r <= NOISE_SEED;
        end else if (in_data[7]) begin
          tp_r[ch_w] <= {tp_r[ch_w][9:4], in_data[3:0]};
        end else begin
          tp_r[ch_w] <= {in_data[5:0], tp_r[ch_w][3:0]};
        end
      end
      if (cmd.start) begin
        if (phase_r >= 8'd192) begin
          phase_r <= phase_r - 8'd192;
          ticks_r <= 3'd5;
        end else begin
          phase_r <= phase_r + 8'd48;
          ticks_r <= 3'd4;
        end
      end
      if (cmd.seg && !cmd.seg_last) begin
        cd_r   <= cd_nxt;
        high_r <= high_nxt;
        nph_r  <= nph_nxt;
        lfsr_r <= lfsr_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      first_len_r <= 8'(TICK_CLOCKS) - phase_r;
      acc_r       <= '0;
    end else if (cmd.seg) begin
      acc_r <= acc_r + ACC_W'(prod);
    end
    if (cmd.div_init) begin
      m_r   <= mag[MAG_W+3:4];
      neg_r <= acc_r[ACC_W-1];
    end
    if (cmd.div_step) begin
      q_r <= qprod[RECIP_SHIFT +: QUOT_W];
    end
    if (cmd.emit) begin
      sample_r <= neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
    end
  end

  assign stat.ticks = ticks_r;
  assign sample     = sample_r;

endmodule
